### hdl/lbbm_pkg.sv
// Package for the LRU block buffer manager.
// Holds op and status codes, controller state type and control structs.
// Depends on nothing; used by every other file of the block.
package lbbm_pkg;

  localparam logic [1:0] OP_ALLOC  = 2'd0;
  localparam logic [1:0] OP_LOOKUP = 2'd1;
  localparam logic [1:0] OP_DIRTY  = 2'd2;

  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_OOB  = 2'd1;
  localparam logic [1:0] STAT_MISS = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SETUP,
    S_SCAN,
    S_LAST,
    S_UPDATE
  } lbbm_state_t;

  typedef struct packed {
    logic latch;
    logic scan_init;
    logic scan_rd;
    logic update;
  } lbbm_cmd_t;

  typedef struct packed {
    logic oob;
    logic scan_last;
  } lbbm_stat_t;

endpackage

### hdl/lbbm_ctrl.sv
// Controller state machine of the LRU block buffer manager.
// Sequences setup, table scan and update; depends on lbbm_pkg.
module lbbm_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  lbbm_pkg::lbbm_stat_t stat,
  output lbbm_pkg::lbbm_cmd_t  cmd,
  output logic               busy
);

  lbbm_pkg::lbbm_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lbbm_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lbbm_pkg::S_IDLE: begin
        if (start) state_nxt = lbbm_pkg::S_SETUP;
      end
      lbbm_pkg::S_SETUP: begin
        state_nxt = stat.oob ? lbbm_pkg::S_UPDATE : lbbm_pkg::S_SCAN;
      end
      lbbm_pkg::S_SCAN: begin
        if (stat.scan_last) state_nxt = lbbm_pkg::S_LAST;
      end
      lbbm_pkg::S_LAST: begin
        state_nxt = lbbm_pkg::S_UPDATE;
      end
      lbbm_pkg::S_UPDATE: begin
        state_nxt = lbbm_pkg::S_IDLE;
      end
      default: begin
        state_nxt = lbbm_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    unique case (state_r)
      lbbm_pkg::S_IDLE: begin
        busy      = 1'b0;
        cmd.latch = start;
      end
      lbbm_pkg::S_SETUP: begin
        cmd.scan_init = 1'b1;
      end
      lbbm_pkg::S_SCAN: begin
        cmd.scan_rd = 1'b1;
      end
      lbbm_pkg::S_LAST: begin
        cmd = '0;
      end
      lbbm_pkg::S_UPDATE: begin
        cmd.update = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

### hdl/lbbm_dpath.sv
// Datapath of the LRU block buffer manager: flags, tag and age memories,
// scan trackers and the result register. Depends on lbbm_pkg.
module lbbm_dpath #(
  parameter int BUFFER_ENTRIES = 32,
  parameter int DISK_SIZE      = 8192,
  parameter int AGE_WIDTH      = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  lbbm_pkg::lbbm_cmd_t  cmd,
  output lbbm_pkg::lbbm_stat_t stat,
  input  logic [1:0]           in_op,
  input  logic [15:0]          in_block_num,
  output logic                 out_valid,
  output logic [1:0]           out_status,
  output logic [4:0]           out_buffer_index,
  output logic                 out_write_back,
  output logic [15:0]          out_write_back_block
);

  localparam int IW = $clog2(BUFFER_ENTRIES);
  localparam logic [IW-1:0] LAST_IDX = IW'(BUFFER_ENTRIES - 1);
  localparam logic [16:0] DISK_LIMIT = 17'(DISK_SIZE);

  logic [1:0]  op_r;
  logic [15:0] blk_r;

  logic [BUFFER_ENTRIES-1:0] occ_r;
  logic [BUFFER_ENTRIES-1:0] dirty_r;

  logic [15:0]          tag_mem [BUFFER_ENTRIES];
  logic [AGE_WIDTH-1:0] age_mem [BUFFER_ENTRIES];
  logic [15:0]          tag_q_r;
  logic [AGE_WIDTH-1:0] age_q_r;

  logic [IW-1:0] cnt_r;
  logic [IW-1:0] proc_idx_r;
  logic          proc_vld_r;

  logic                 free_found_r;
  logic [IW-1:0]        free_idx_r;
  logic                 match_found_r;
  logic [IW-1:0]        match_idx_r;
  logic [IW-1:0]        old_idx_r;
  logic [AGE_WIDTH-1:0] old_age_r;
  logic [15:0]          old_tag_r;

  logic                 oob;
  logic                 is_alloc;
  logic                 occ_j;
  logic [AGE_WIDTH-1:0] aged;
  logic                 age_we;
  logic [IW-1:0]        age_waddr;
  logic [AGE_WIDTH-1:0] age_wdata;
  logic                 alloc_upd;
  logic [IW-1:0]        sel;
  logic                 victim_wb;
  logic [IW+4:0]        idx_ext;

  logic                 out_valid_r;
  logic [1:0]           out_status_r;
  logic [4:0]           out_idx_r;
  logic                 out_wb_r;
  logic [15:0]          out_wb_blk_r;

  assign oob            = ({1'b0, blk_r} >= DISK_LIMIT);
  assign is_alloc       = (op_r == lbbm_pkg::OP_ALLOC);
  assign stat.oob       = oob;
  assign stat.scan_last = (cnt_r == LAST_IDX);

  assign occ_j = occ_r[proc_idx_r];
  assign aged  = (occ_j && (age_q_r != '1)) ? age_q_r + 1'b1 : age_q_r;

  assign alloc_upd = cmd.update && is_alloc && !oob;
  assign sel       = free_found_r ? free_idx_r : old_idx_r;
  assign victim_wb = !free_found_r && dirty_r[old_idx_r];

  always_comb begin
    age_we    = 1'b0;
    age_waddr = proc_idx_r;
    age_wdata = aged;
    if (alloc_upd) begin
      age_we    = 1'b1;
      age_waddr = sel;
      age_wdata = '0;
    end else if (proc_vld_r && is_alloc && occ_j) begin
      age_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r  <= in_op;
      blk_r <= in_block_num;
    end
  end

  always_ff @(posedge clk) begin
    if (alloc_upd) begin
      tag_mem[sel] <= blk_r;
    end
    tag_q_r <= tag_mem[cnt_r];
  end

  always_ff @(posedge clk) begin
    if (age_we) begin
      age_mem[age_waddr] <= age_wdata;
    end
    age_q_r <= age_mem[cnt_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r      <= '0;
      proc_vld_r <= 1'b0;
    end else begin
      proc_vld_r <= cmd.scan_rd;
      if (cmd.scan_init) begin
        cnt_r <= '0;
      end else if (cmd.scan_rd) begin
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_rd) begin
      proc_idx_r <= cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_init) begin
      free_found_r  <= 1'b0;
      match_found_r <= 1'b0;
    end else if (proc_vld_r) begin
      if (!occ_j && !free_found_r) begin
        free_found_r <= 1'b1;
        free_idx_r   <= proc_idx_r;
      end
      if (occ_j && (tag_q_r == blk_r) && !match_found_r) begin
        match_found_r <= 1'b1;
        match_idx_r   <= proc_idx_r;
      end
      if ((proc_idx_r == '0) || (aged > old_age_r)) begin
        old_idx_r <= proc_idx_r;
        old_age_r <= aged;
        old_tag_r <= tag_q_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r   <= '0;
      dirty_r <= '0;
    end else if (cmd.update && !oob) begin
      if (is_alloc) begin
        occ_r[sel]   <= 1'b1;
        dirty_r[sel] <= 1'b0;
      end else if ((op_r == lbbm_pkg::OP_DIRTY) && match_found_r) begin
        dirty_r[match_idx_r] <= 1'b1;
      end
    end
  end

  always_comb begin
    idx_ext = '0;
    if (!oob) begin
      if (is_alloc) begin
        idx_ext = (IW + 5)'(sel);
      end else if (match_found_r) begin
        idx_ext = (IW + 5)'(match_idx_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.update;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      out_idx_r    <= idx_ext[4:0];
      out_wb_r     <= 1'b0;
      out_wb_blk_r <= '0;
      if (oob) begin
        out_status_r <= lbbm_pkg::STAT_OOB;
      end else if (is_alloc) begin
        out_status_r <= lbbm_pkg::STAT_OK;
        out_wb_r     <= victim_wb;
        out_wb_blk_r <= victim_wb ? old_tag_r : 16'd0;
      end else if (match_found_r) begin
        out_status_r <= lbbm_pkg::STAT_OK;
      end else begin
        out_status_r <= lbbm_pkg::STAT_MISS;
      end
    end
  end

  assign out_valid            = out_valid_r;
  assign out_status           = out_status_r;
  assign out_buffer_index     = out_idx_r;
  assign out_write_back       = out_wb_r;
  assign out_write_back_block = out_wb_blk_r;

endmodule

### hdl/lru_block_buffer_manager_unit.sv
// Top level of the LRU block buffer manager.
// Joins the controller lbbm_ctrl and the datapath lbbm_dpath; uses lbbm_pkg.
//
// Channel  Ports                                        Handshake
// input    in_op, in_block_num                          start && !busy
// result   out_status, out_buffer_index, out_write_back, out_valid, one cycle
//          out_write_back_block
//
// An item passes from acceptance through the setup, scan, last and update states to the registered
// result strobe; the scan reads one tag and age memory entry per cycle.
// An out-of-bound block number skips the scan and goes from setup straight to update.
// Reset is synchronous and clears all flags; tag and age memories need no clearing.
// The receiver cannot stall; a new item may be accepted in the cycle of the strobe.
module lru_block_buffer_manager_unit #(
  parameter int BUFFER_ENTRIES = 32,
  parameter int DISK_SIZE      = 8192,
  parameter int AGE_WIDTH      = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_op,
  input  logic [15:0] in_block_num,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [4:0]  out_buffer_index,
  output logic        out_write_back,
  output logic [15:0] out_write_back_block
);

  lbbm_pkg::lbbm_cmd_t  cmd;
  lbbm_pkg::lbbm_stat_t stat;

  lbbm_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  lbbm_dpath #(
    .BUFFER_ENTRIES (BUFFER_ENTRIES),
    .DISK_SIZE      (DISK_SIZE),
    .AGE_WIDTH      (AGE_WIDTH)
  ) u_dpath (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .stat                 (stat),
    .in_op                (in_op),
    .in_block_num         (in_block_num),
    .out_valid            (out_valid),
    .out_status           (out_status),
    .out_buffer_index     (out_buffer_index),
    .out_write_back       (out_write_back),
    .out_write_back_block (out_write_back_block)
  );

`ifndef SYNTHESIS
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != lbbm_pkg::STAT_OK)) |->
      ((out_buffer_index == 5'd0) && !out_write_back))
    else $error("failed item carries index or write-back");

  a_wb_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_write_back) |-> (out_status == lbbm_pkg::STAT_OK))
    else $error("write-back without success");
`endif

endmodule

### verif/tb_lru_block_buffer_manager_unit.sv
`timescale 1ns / 100ps
// Self-checking testbench for lru_block_buffer_manager_unit.
// Drives a directed table, then random items; a pool predictor checks all but typed table rows.
// Depends on lbbm_pkg and the RTL of the block only.
module tb_lru_block_buffer_manager_unit;

  localparam int NUM_ENTRIES = 32;
  localparam int BLOCK_LIMIT = 8192;
  localparam int AGE_BITS = 16;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int DIR_ROWS = 20;
  localparam int TOTAL_ITEMS = 650;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    logic [1:0]  status;
    logic [4:0]  index;
    logic        wb;
    logic [15:0] wb_block;
  } pool_result_t;

  typedef struct packed {
    logic [1:0]   op;
    logic [15:0]  blk;
    logic         typed;
    pool_result_t res;
  } directed_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic start;
  logic busy;
  logic [1:0] in_op;
  logic [15:0] in_block_num;
  logic out_valid;
  logic [1:0] out_status;
  logic [4:0] out_buffer_index;
  logic out_write_back;
  logic [15:0] out_write_back_block;

  logic occ_q [NUM_ENTRIES];
  logic dirty_q [NUM_ENTRIES];
  logic [15:0] tag_q [NUM_ENTRIES];
  logic [AGE_BITS-1:0] age_q [NUM_ENTRIES];

  pool_result_t pending_pool_results [$];
  int mismatches = 0;
  int stall_cycles = 0;

  logic [1:0] cur_op;
  logic [15:0] cur_blk;
  logic cur_typed;
  pool_result_t cur_res;

  directed_row_t directed_rows [DIR_ROWS] = '{
    '{lbbm_pkg::OP_LOOKUP, 16'd0, 1'b1, '{lbbm_pkg::STAT_MISS, 5'd0, 1'b0, 16'd0}},
    '{lbbm_pkg::OP_DIRTY, 16'd5, 1'b1, '{lbbm_pkg::STAT_MISS, 5'd0, 1'b0, 16'd0}},
    '{lbbm_pkg::OP_ALLOC, 16'd8192, 1'b1, '{lbbm_pkg::STAT_OOB, 5'd0, 1'b0, 16'd0}},
    '{lbbm_pkg::OP_LOOKUP, 16'hFFFF, 1'b1, '{lbbm_pkg::STAT_OOB, 5'd0, 1'b0, 16'd0}},
    '{lbbm_pkg::OP_DIRTY, 16'hA000, 1'b1, '{lbbm_pkg::STAT_OOB, 5'd0, 1'b0, 16'd0}},
    '{lbbm_pkg::OP_ALLOC, 16'd0, 1'b1, '{lbbm_pkg::STAT_OK, 5'd0, 1'b0, 16'd0}},
    '{lbbm_pkg::OP_ALLOC, 16'd8191, 1'b1, '{lbbm_pkg::STAT_OK, 5'd1, 1'b0, 16'd0}},
    '{lbbm_pkg::OP_LOOKUP, 16'd8191, 1'b1, '{lbbm_pkg::STAT_OK, 5'd1, 1'b0, 16'd0}},
    '{lbbm_pkg::OP_DIRTY, 16'd0, 1'b1, '{lbbm_pkg::STAT_OK, 5'd0, 1'b0, 16'd0}},
    '{lbbm_pkg::OP_ALLOC, 16'd0, 1'b1, '{lbbm_pkg::STAT_OK, 5'd2, 1'b0, 16'd0}},
    '{lbbm_pkg::OP_LOOKUP, 16'd0, 1'b1, '{lbbm_pkg::STAT_OK, 5'd0, 1'b0, 16'd0}},
    '{lbbm_pkg::OP_DIRTY, 16'd0, 1'b1, '{lbbm_pkg::STAT_OK, 5'd0, 1'b0, 16'd0}},
    '{OP_UNUSED, 16'd8191, 1'b1, '{lbbm_pkg::STAT_OK, 5'd1, 1'b0, 16'd0}},
    '{OP_UNUSED, 16'd4242, 1'b1, '{lbbm_pkg::STAT_MISS, 5'd0, 1'b0, 16'd0}},
    '{lbbm_pkg::OP_ALLOC, 16'd8191, 1'b1, '{lbbm_pkg::STAT_OK, 5'd3, 1'b0, 16'd0}},
    '{lbbm_pkg::OP_ALLOC, 16'd4095, 1'b0, '{lbbm_pkg::STAT_OK, 5'd0, 1'b0, 16'd0}},
    '{lbbm_pkg::OP_DIRTY, 16'd4095, 1'b0, '{lbbm_pkg::STAT_OK, 5'd0, 1'b0, 16'd0}},
    '{lbbm_pkg::OP_ALLOC, 16'h5555, 1'b1, '{lbbm_pkg::STAT_OOB, 5'd0, 1'b0, 16'd0}},
    '{lbbm_pkg::OP_LOOKUP, 16'h1AAA, 1'b1, '{lbbm_pkg::STAT_MISS, 5'd0, 1'b0, 16'd0}},
    '{lbbm_pkg::OP_ALLOC, 16'h1555, 1'b0, '{lbbm_pkg::STAT_OK, 5'd0, 1'b0, 16'd0}}
  };

  lru_block_buffer_manager_unit dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .start                (start),
    .busy                 (busy),
    .in_op                (in_op),
    .in_block_num         (in_block_num),
    .out_valid            (out_valid),
    .out_status           (out_status),
    .out_buffer_index     (out_buffer_index),
    .out_write_back       (out_write_back),
    .out_write_back_block (out_write_back_block)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Updates the pool copy for one item and returns the result it must produce.
  function automatic pool_result_t predict_pool_access(input logic [1:0] op,
                                                       input logic [15:0] blk);
    pool_result_t res;
    int sel;
    int i;
    res = '0;
    sel = -1;
    if (blk >= BLOCK_LIMIT) begin
      res.status = lbbm_pkg::STAT_OOB;
    end else if (op == lbbm_pkg::OP_ALLOC) begin
      for (i = 0; i < NUM_ENTRIES; i++) begin
        if (occ_q[i] && age_q[i] != '1) age_q[i] = age_q[i] + 1'b1;
      end
      for (i = 0; i < NUM_ENTRIES; i++) begin
        if (!occ_q[i] && sel < 0) sel = i;
      end
      if (sel < 0) begin
        sel = 0;
        for (i = 1; i < NUM_ENTRIES; i++) begin
          if (age_q[i] > age_q[sel]) sel = i;
        end
        if (dirty_q[sel]) begin
          res.wb = 1'b1;
          res.wb_block = tag_q[sel];
        end
      end
      occ_q[sel] = 1'b1;
      dirty_q[sel] = 1'b0;
      tag_q[sel] = blk;
      age_q[sel] = '0;
      res.index = sel[4:0];
    end else begin
      for (i = 0; i < NUM_ENTRIES; i++) begin
        if (occ_q[i] && tag_q[i] == blk && sel < 0) sel = i;
      end
      if (sel < 0) begin
        res.status = lbbm_pkg::STAT_MISS;
      end else begin
        if (op == lbbm_pkg::OP_DIRTY) dirty_q[sel] = 1'b1;
        res.index = sel[4:0];
      end
    end
    return res;
  endfunction

  function automatic logic [15:0] held_block();
    int i;
    int k;
    for (k = 0; k < 8; k++) begin
      i = $urandom_range(NUM_ENTRIES - 1);
      if (occ_q[i]) return tag_q[i];
    end
    return 16'($urandom_range(BLOCK_LIMIT - 1));
  endfunction

  // Mostly allocations and hits on held blocks, so the pool fills and evicts dirty entries.
  task automatic load_next_item(input int n);
    int r;
    int q;
    cur_typed = 1'b0;
    cur_res = '0;
    if (n < DIR_ROWS) begin
      cur_op = directed_rows[n].op;
      cur_blk = directed_rows[n].blk;
      cur_typed = directed_rows[n].typed;
      cur_res = directed_rows[n].res;
    end else begin
      r = $urandom_range(99);
      q = $urandom_range(9);
      if (r < 8) begin
        cur_op = 2'($urandom_range(3));
        cur_blk = 16'($urandom_range(65535, BLOCK_LIMIT));
      end else if (r < 50) begin
        cur_op = lbbm_pkg::OP_ALLOC;
        if (q < 6) cur_blk = 16'($urandom_range(63));
        else if (q < 8) cur_blk = 16'($urandom_range(BLOCK_LIMIT - 1));
        else if (q == 8) cur_blk = held_block();
        else cur_blk = $urandom_range(1) ? 16'(BLOCK_LIMIT - 1) : 16'd0;
      end else if (r < 72) begin
        cur_op = lbbm_pkg::OP_DIRTY;
        cur_blk = (q < 8) ? held_block() : 16'($urandom_range(BLOCK_LIMIT - 1));
      end else if (r < 96) begin
        cur_op = lbbm_pkg::OP_LOOKUP;
        cur_blk = (q < 7) ? held_block() : 16'($urandom_range(BLOCK_LIMIT - 1));
      end else begin
        cur_op = OP_UNUSED;
        cur_blk = (q < 5) ? held_block() : 16'($urandom_range(BLOCK_LIMIT - 1));
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_pool_results.size() == 0) begin
        if (mismatches < 10) begin
          $display("unexpected result: status %0d index %0d wb %0b wb_block %0d",
                   out_status, out_buffer_index, out_write_back, out_write_back_block);
        end
        mismatches++;
      end else begin
        if (out_status !== pending_pool_results[0].status
            || out_buffer_index !== pending_pool_results[0].index
            || out_write_back !== pending_pool_results[0].wb
            || out_write_back_block !== pending_pool_results[0].wb_block) begin
          if (mismatches < 10) begin
            $display("mismatch: expected %0d %0d %0b %0d, got %0d %0d %0b %0d",
                     pending_pool_results[0].status, pending_pool_results[0].index,
                     pending_pool_results[0].wb, pending_pool_results[0].wb_block,
                     out_status, out_buffer_index, out_write_back, out_write_back_block);
          end
          mismatches++;
        end
        void'(pending_pool_results.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    int n_drawn;
    int n_accepted;
    int idle_pct;
    logic accepted;
    n_drawn = 0;
    n_accepted = 0;
    rst_n <= 1'b0;
    start <= 1'b0;
    in_op <= lbbm_pkg::OP_ALLOC;
    in_block_num <= 16'd0;
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      occ_q[i] = 1'b0;
      dirty_q[i] = 1'b0;
      tag_q[i] = 16'd0;
      age_q[i] = '0;
    end
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    while (n_accepted < TOTAL_ITEMS) begin
      @(posedge clk);
      accepted = start && !busy;
      if (accepted) begin
        if (cur_typed) begin
          void'(predict_pool_access(cur_op, cur_blk));
          pending_pool_results.push_back(cur_res);
        end else begin
          pending_pool_results.push_back(predict_pool_access(cur_op, cur_blk));
        end
        n_accepted++;
      end
      if ((accepted || !start) && n_drawn < TOTAL_ITEMS) begin
        idle_pct = (n_drawn < 217) ? 11 : (n_drawn < 434) ? 83 : 0;
        if ($urandom_range(99) >= idle_pct) begin
          load_next_item(n_drawn);
          n_drawn++;
          start <= 1'b1;
          in_op <= cur_op;
          in_block_num <= cur_blk;
        end else begin
          start <= 1'b0;
        end
      end else if (accepted) begin
        start <= 1'b0;
      end
    end

    while (pending_pool_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### files.f
hdl/lbbm_pkg.sv
hdl/lbbm_ctrl.sv
hdl/lbbm_dpath.sv
hdl/lru_block_buffer_manager_unit.sv
verif/tb_lru_block_buffer_manager_unit.sv
